>>> hw/rtl/acp_pkg.sv
// Shared types, constants and helpers for the ADC CSV line parser.
package acp_pkg;

   localparam int RAW_COUNT = 5;
   localparam int PREFIX_LEN = 5;

   localparam logic [3:0] FIELD_PREFIX = 4'd0;
   localparam logic [3:0] FIELD_SEQ = 4'd1;
   localparam logic [3:0] FIELD_MS = 4'd2;
   localparam logic [3:0] FIELD_MASK = 4'd3;
   localparam logic [3:0] FIELD_RAW0 = 4'd4;
   localparam logic [3:0] FIELD_TRACK = 4'd9;
   localparam logic [3:0] FIELD_LAST = 4'd10;
   localparam logic [3:0] COUNT_SAT = 4'd11;
   localparam logic [3:0] COUNT_NINE = 4'd8;
   localparam logic [3:0] COUNT_TEN = 4'd9;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_COUNT = 3'd1;
   localparam logic [2:0] ST_PREFIX = 3'd2;
   localparam logic [2:0] ST_SEQ = 3'd3;
   localparam logic [2:0] ST_MS = 3'd4;
   localparam logic [2:0] ST_MASK = 3'd5;
   localparam logic [2:0] ST_RAW = 3'd6;
   localparam logic [2:0] ST_TRACK = 3'd7;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [63:0] U64_TENTH = 64'd1844674407370955161;
   localparam logic [63:0] S32_POS_LIMIT = 64'd2147483647;
   localparam logic [63:0] S32_NEG_LIMIT = 64'd2147483648;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_valid;
      logic       line_end;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         bad_raw_index;
      logic signed [31:0] seq;
      logic [63:0]        dev_time_ms;
      logic signed [31:0] channel_mask;
      logic signed [31:0] raw0;
      logic signed [31:0] raw1;
      logic signed [31:0] raw2;
      logic signed [31:0] raw3;
      logic signed [31:0] raw4;
      logic               tracking_present;
      logic               tracking_on;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] acc;
      logic        minus;
      logic        started;
      logic        digit;
      logic        bad;
   } token_type;

   typedef struct packed {
      logic [2:0] progress;
      logic       failed;
   } prefix_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0: ch = 8'h4F;
         3'd1: ch = 8'h46;
         3'd2: ch = 8'h41;
         3'd3: ch = 8'h44;
         3'd4: ch = 8'h43;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/acp_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface acp_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/acp_token_step.sv
// Per-byte update of the prefix matcher and the numeric token accumulator.
module acp_token_step (
   input  logic [3:0]         field,
   input  logic [7:0]         char_code,
   input  acp_pkg::token_type  token,
   input  acp_pkg::prefix_type prefix,
   output acp_pkg::token_type  token_next,
   output acp_pkg::prefix_type prefix_next
);
   import acp_pkg::*;

   logic        is_signed;
   logic [3:0]  digit;
   logic [63:0] product;
   logic [63:0] limit;

   assign is_signed = (field != FIELD_MS);
   assign digit = char_code[3:0];
   assign product = {token.acc[60:0], 3'b000} + {token.acc[62:0], 1'b0} + {60'd0, digit};
   assign limit = token.minus ? S32_NEG_LIMIT : S32_POS_LIMIT;

   always_comb begin
      token_next = token;
      prefix_next = prefix;
      if (field < FIELD_LAST) begin
         token_next.started = 1'b1;
         if (field == FIELD_PREFIX) begin
            if (!prefix.failed && (prefix.progress < 3'(PREFIX_LEN)) &&
                (char_code == prefix_char(prefix.progress))) begin
               prefix_next.progress = prefix.progress + 3'd1;
            end else begin
               prefix_next.failed = 1'b1;
            end
         end else if (!token.bad) begin
            if ((char_code == CHAR_MINUS) && is_signed && !token.started) begin
               token_next.minus = 1'b1;
            end else if ((char_code < CHAR_ZERO) || (char_code > CHAR_NINE)) begin
               token_next.bad = 1'b1;
            end else begin
               token_next.digit = 1'b1;
               if (is_signed) begin
                  if (product > limit) begin
                     token_next.bad = 1'b1;
                  end else begin
                     token_next.acc = product;
                  end
               end else if ((token.acc > U64_TENTH) ||
                            ((token.acc == U64_TENTH) && (digit > 4'd5))) begin
                  token_next.bad = 1'b1;
               end else begin
                  token_next.acc = product;
               end
            end
         end
      end
   end

endmodule

>>> hw/rtl/acp_line_ctrl.sv
// Line state: field counter, field close, error capture, held values and result build.
module acp_line_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  acp_pkg::req_payload_type beat,
   output acp_pkg::rsp_payload_type result
);
   import acp_pkg::*;

   logic [3:0]  field_count_ff, field_count_in;
   prefix_type  prefix_ff, prefix_in;
   token_type   token_ff, token_in;
   logic [2:0]  first_error_ff, first_error_in;
   logic [2:0]  error_slot_ff, error_slot_in;
   logic [31:0] held_seq_ff, held_seq_in;
   logic [63:0] held_ms_ff, held_ms_in;
   logic [31:0] held_mask_ff, held_mask_in;
   logic [31:0] held_raw_ff [RAW_COUNT];
   logic [31:0] held_raw_in [RAW_COUNT];
   logic        held_tracking_ff, held_tracking_in;

   token_type   step_token;
   prefix_type  step_prefix;

   logic        is_comma;
   logic        do_close;
   logic        field_ok;
   logic [31:0] magnitude;
   logic [31:0] signed_value;
   logic [2:0]  raw_index;
   logic [2:0]  status;

   acp_token_step u_step (
      .field      (field_count_ff),
      .char_code  (beat.char_code),
      .token      (token_ff),
      .prefix     (prefix_ff),
      .token_next (step_token),
      .prefix_next(step_prefix)
   );

   assign is_comma = beat.char_valid && (beat.char_code == CHAR_COMMA);

   always_comb begin
      field_count_in = field_count_ff;
      prefix_in = prefix_ff;
      token_in = token_ff;
      first_error_in = first_error_ff;
      error_slot_in = error_slot_ff;
      held_seq_in = held_seq_ff;
      held_ms_in = held_ms_ff;
      held_mask_in = held_mask_ff;
      held_raw_in = held_raw_ff;
      held_tracking_in = held_tracking_ff;
      field_ok = 1'b0;
      magnitude = '0;
      signed_value = '0;
      raw_index = '0;
      do_close = 1'b0;

      if (beat.char_valid && !is_comma) begin
         token_in = step_token;
         prefix_in = step_prefix;
      end

      for (int pass = 0; pass < 2; pass++) begin
         do_close = (pass == 0) ? is_comma : beat.line_end;
         if (do_close) begin
            field_ok = token_in.digit && !token_in.bad;
            magnitude = token_in.acc[31:0];
            signed_value = token_in.minus ? (32'd0 - magnitude) : magnitude;
            raw_index = 3'(field_count_in - FIELD_RAW0);
            if (field_count_in == FIELD_PREFIX) begin
               if ((prefix_in.failed || (prefix_in.progress != 3'(PREFIX_LEN))) &&
                   (first_error_in == ST_OK)) begin
                  first_error_in = ST_PREFIX;
                  error_slot_in = '0;
               end
            end else if (field_count_in == FIELD_SEQ) begin
               if (field_ok) begin
                  held_seq_in = signed_value;
               end else if (first_error_in == ST_OK) begin
                  first_error_in = ST_SEQ;
                  error_slot_in = '0;
               end
            end else if (field_count_in == FIELD_MS) begin
               if (field_ok) begin
                  held_ms_in = token_in.acc;
               end else if (first_error_in == ST_OK) begin
                  first_error_in = ST_MS;
                  error_slot_in = '0;
               end
            end else if (field_count_in == FIELD_MASK) begin
               if (field_ok) begin
                  held_mask_in = signed_value;
               end else if (first_error_in == ST_OK) begin
                  first_error_in = ST_MASK;
                  error_slot_in = '0;
               end
            end else if (field_count_in < FIELD_TRACK) begin
               if (field_ok) begin
                  held_raw_in[raw_index] = signed_value;
               end else if (first_error_in == ST_OK) begin
                  first_error_in = ST_RAW;
                  error_slot_in = raw_index;
               end
            end else if (field_count_in == FIELD_TRACK) begin
               if (field_ok) begin
                  held_tracking_in = (token_in.acc != 64'd0);
               end else if (first_error_in == ST_OK) begin
                  first_error_in = ST_TRACK;
                  error_slot_in = '0;
               end
            end
            token_in = '0;
            if ((pass == 0) && (field_count_in != COUNT_SAT)) begin
               field_count_in = field_count_in + 4'd1;
            end
         end
      end
   end

   always_comb begin
      if ((field_count_in != COUNT_NINE) && (field_count_in != COUNT_TEN)) begin
         status = ST_COUNT;
      end else begin
         status = first_error_in;
      end
      result = '0;
      result.status = status;
      if (status == ST_RAW) begin
         result.bad_raw_index = error_slot_in;
      end
      if (status == ST_OK) begin
         result.seq = held_seq_in;
         result.dev_time_ms = held_ms_in;
         result.channel_mask = held_mask_in;
         result.raw0 = held_raw_in[0];
         result.raw1 = held_raw_in[1];
         result.raw2 = held_raw_in[2];
         result.raw3 = held_raw_in[3];
         result.raw4 = held_raw_in[4];
         result.tracking_present = (field_count_in == COUNT_TEN);
         result.tracking_on = held_tracking_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff <= '0;
         prefix_ff <= '0;
         token_ff <= '0;
         first_error_ff <= ST_OK;
         error_slot_ff <= '0;
         held_seq_ff <= '0;
         held_ms_ff <= '0;
         held_mask_ff <= '0;
         held_tracking_ff <= 1'b0;
         for (int i = 0; i < RAW_COUNT; i++) begin
            held_raw_ff[i] <= '0;
         end
      end else if (advance) begin
         if (beat.line_end) begin
            field_count_ff <= '0;
            prefix_ff <= '0;
            token_ff <= '0;
            first_error_ff <= ST_OK;
            error_slot_ff <= '0;
            held_seq_ff <= '0;
            held_ms_ff <= '0;
            held_mask_ff <= '0;
            held_tracking_ff <= 1'b0;
            for (int i = 0; i < RAW_COUNT; i++) begin
               held_raw_ff[i] <= '0;
            end
         end else begin
            field_count_ff <= field_count_in;
            prefix_ff <= prefix_in;
            token_ff <= token_in;
            first_error_ff <= first_error_in;
            error_slot_ff <= error_slot_in;
            held_seq_ff <= held_seq_in;
            held_ms_ff <= held_ms_in;
            held_mask_ff <= held_mask_in;
            held_tracking_ff <= held_tracking_in;
            for (int i = 0; i < RAW_COUNT; i++) begin
               held_raw_ff[i] <= held_raw_in[i];
            end
         end
      end
   end

endmodule

>>> hw/rtl/adc_csv_packet_parser.sv
// Top level: input beat register, line parser, result register, port checks.
// A line-end beat passes from the input beat register through the line parser into the result register.
// Throughput: one beat per cycle; the input register and line state advance every cycle
// unless a line-end beat waits on a full result register.
// Reset (synchronous, active high) clears both valid flags and all line state.
module adc_csv_packet_parser (
   input logic          clock,
   input logic          reset,
   acp_stream_if.sink   req_if,
   acp_stream_if.source rsp_if
);
   import acp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_beat_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_beat_ff;
   rsp_payload_type line_result;
   logic            advance;
   logic            take_req;

   assign advance = in_valid_ff &&
                    (!in_beat_ff.line_end || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign take_req = req_if.valid && req_if.ready;

   assign in_valid_in = take_req || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_beat_ff.line_end) || (rsp_valid_ff && !rsp_if.ready);

   acp_line_ctrl u_line (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .beat   (in_beat_ff),
      .result (line_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_beat_ff <= req_if.payload;
      end
      if (advance && in_beat_ff.line_end) begin
         rsp_beat_ff <= line_result;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_beat_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.payload.status != ST_OK) |->
         (rsp_if.payload.seq == 32'sd0) && (rsp_if.payload.dev_time_ms == 64'd0) &&
         !rsp_if.payload.tracking_present)
      else $error("failed line carries parsed values");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.payload.bad_raw_index != 3'd0) |->
         (rsp_if.payload.status == ST_RAW) && (rsp_if.payload.bad_raw_index < 3'(RAW_COUNT)))
      else $error("raw index outside a raw error");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.tracking_on |-> rsp_if.payload.tracking_present)
      else $error("tracking flag without tracking field");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_beat_ff.line_end |-> advance)
      else $error("non-terminal beat stalled");

endmodule

>>> sim/adc_csv_packet_parser_test.sv
// Self-checking testbench for adc_csv_packet_parser: directed and random CSV lines.
module adc_csv_packet_parser_test;
   import acp_pkg::*;

   localparam logic [39:0] PREFIX_TEXT = "OFADC";

   logic clock;
   logic reset;

   acp_stream_if #(.payload_type(req_payload_type)) req_ch ();
   acp_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   adc_csv_packet_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // line parser state
   logic [3:0]  fld_idx;
   logic [2:0]  pfx_pos;
   logic        pfx_bad;
   logic [63:0] tok_acc;
   logic        tok_minus;
   logic        tok_started;
   logic        tok_digit;
   logic        tok_bad;
   logic [2:0]  err_code;
   logic [2:0]  err_slot;
   logic [31:0] val_seq;
   logic [63:0] val_ms;
   logic [31:0] val_mask;
   logic [31:0] val_raw [RAW_COUNT];
   logic        val_track;

   rsp_payload_type pending_reports[$];
   logic [7:0]      line_bytes[$];

   int          error_count = 0;
   int          reports_checked = 0;
   int          lines_sent = 0;
   int          bytes_sent = 0;
   int          burst_left = 0;
   int          gap_len = 0;
   logic [9:0]  rx_tick = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void tok_clear();
      tok_acc = '0;
      tok_minus = 1'b0;
      tok_started = 1'b0;
      tok_digit = 1'b0;
      tok_bad = 1'b0;
   endfunction

   function automatic void line_clear();
      fld_idx = '0;
      pfx_pos = '0;
      pfx_bad = 1'b0;
      tok_clear();
      err_code = ST_OK;
      err_slot = '0;
      val_seq = '0;
      val_ms = '0;
      val_mask = '0;
      for (int i = 0; i < RAW_COUNT; i++) val_raw[i] = '0;
      val_track = 1'b0;
   endfunction

   function automatic void flag_error(input logic [2:0] code, input logic [2:0] slot);
      if (err_code == ST_OK) begin
         err_code = code;
         err_slot = slot;
      end
   endfunction

   function automatic void absorb_char(input logic [7:0] ch);
      logic        first_byte;
      logic        sgn;
      logic [63:0] dgt;
      logic [63:0] nxt;
      logic [63:0] lim;
      first_byte = !tok_started;
      if (fld_idx >= FIELD_LAST) return;
      tok_started = 1'b1;
      if (fld_idx == FIELD_PREFIX) begin
         if (!pfx_bad && pfx_pos < PREFIX_LEN && ch == PREFIX_TEXT[39 - 8 * pfx_pos -: 8])
            pfx_pos = pfx_pos + 3'd1;
         else
            pfx_bad = 1'b1;
         return;
      end
      if (tok_bad) return;
      sgn = (fld_idx != FIELD_MS);
      if (ch == CHAR_MINUS && sgn && first_byte) begin
         tok_minus = 1'b1;
         return;
      end
      if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
         tok_bad = 1'b1;
         return;
      end
      dgt = 64'(ch - CHAR_ZERO);
      tok_digit = 1'b1;
      if (sgn) begin
         lim = tok_minus ? S32_NEG_LIMIT : S32_POS_LIMIT;
         nxt = tok_acc * 64'd10 + dgt;
         if (nxt > lim) tok_bad = 1'b1;
         else tok_acc = nxt;
      end else if (tok_acc > U64_TENTH || (tok_acc == U64_TENTH && dgt > 64'd5)) begin
         tok_bad = 1'b1;
      end else begin
         tok_acc = tok_acc * 64'd10 + dgt;
      end
   endfunction

   function automatic void close_field();
      logic        ok;
      logic [31:0] sval;
      ok = tok_digit && !tok_bad;
      sval = tok_minus ? (32'd0 - tok_acc[31:0]) : tok_acc[31:0];
      if (fld_idx == FIELD_PREFIX) begin
         if (pfx_bad || pfx_pos != PREFIX_LEN) flag_error(ST_PREFIX, 3'd0);
      end else if (fld_idx == FIELD_SEQ) begin
         if (ok) val_seq = sval;
         else flag_error(ST_SEQ, 3'd0);
      end else if (fld_idx == FIELD_MS) begin
         if (ok) val_ms = tok_acc;
         else flag_error(ST_MS, 3'd0);
      end else if (fld_idx == FIELD_MASK) begin
         if (ok) val_mask = sval;
         else flag_error(ST_MASK, 3'd0);
      end else if (fld_idx < FIELD_TRACK) begin
         if (ok) val_raw[fld_idx - FIELD_RAW0] = sval;
         else flag_error(ST_RAW, 3'(fld_idx - FIELD_RAW0));
      end else if (fld_idx == FIELD_TRACK) begin
         if (ok) val_track = (tok_acc != 64'd0);
         else flag_error(ST_TRACK, 3'd0);
      end
      tok_clear();
   endfunction

   function automatic bit parse_beat(input req_payload_type beat, output rsp_payload_type rpt);
      rpt = '0;
      if (beat.char_valid) begin
         if (beat.char_code == CHAR_COMMA) begin
            close_field();
            if (fld_idx < COUNT_SAT) fld_idx = fld_idx + 4'd1;
         end else begin
            absorb_char(beat.char_code);
         end
      end
      if (!beat.line_end) return 1'b0;
      close_field();
      if (fld_idx != COUNT_NINE && fld_idx != COUNT_TEN) rpt.status = ST_COUNT;
      else rpt.status = err_code;
      if (rpt.status == ST_RAW) rpt.bad_raw_index = err_slot;
      if (rpt.status == ST_OK) begin
         rpt.seq = val_seq;
         rpt.dev_time_ms = val_ms;
         rpt.channel_mask = val_mask;
         rpt.raw0 = val_raw[0];
         rpt.raw1 = val_raw[1];
         rpt.raw2 = val_raw[2];
         rpt.raw3 = val_raw[3];
         rpt.raw4 = val_raw[4];
         rpt.tracking_present = (fld_idx == COUNT_TEN);
         rpt.tracking_on = val_track;
      end
      line_clear();
      return 1'b1;
   endfunction

   function automatic string report_text(input rsp_payload_type r);
      return $sformatf("st=%0d idx=%0d seq=%0d ms=%0d mask=%0d raw=%0d/%0d/%0d/%0d/%0d trk=%0b/%0b",
                       r.status, r.bad_raw_index, r.seq, r.dev_time_ms, r.channel_mask,
                       r.raw0, r.raw1, r.raw2, r.raw3, r.raw4,
                       r.tracking_present, r.tracking_on);
   endfunction

   function automatic void note_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      rx_tick <= rx_tick + 10'd1;
      case (rx_tick[9:8])
         2'd0: rsp_ch.ready <= 1'b1;
         2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ch.ready <= (rx_tick[2:0] == 3'd0);
         default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected report %s", report_text(rsp_ch.payload)));
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_ch.payload !== want)
               note_failure($sformatf("expected %s, got %s", report_text(want),
                                      report_text(rsp_ch.payload)));
         end
      end
   end

   task automatic send_beat(input logic [7:0] ch, input logic cv, input logic le);
      req_payload_type beat;
      rsp_payload_type rpt;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      beat.char_code = ch;
      beat.char_valid = cv;
      beat.line_end = le;
      req_ch.valid <= 1'b1;
      req_ch.payload <= beat;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (parse_beat(beat, rpt)) pending_reports.push_back(rpt);
   endtask

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   task automatic send_line(input bit use_marker);
      int n;
      n = line_bytes.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_beat(line_bytes[i], 1'b1, (i == n - 1) && !use_marker);
      end
      if (use_marker || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      bytes_sent += n;
      lines_sent++;
   endtask

   task automatic send_text(input string s, input bit use_marker);
      line_bytes.delete();
      append_text(s);
      send_line(use_marker);
   endtask

   function automatic string s32_text(input bit clean);
      int unsigned pick;
      int          v;
      pick = clean ? $urandom_range(0, 9) : $urandom_range(0, 15);
      case (pick)
         0, 1, 2, 3: begin
            v = $urandom_range(0, 999);
            if ($urandom_range(0, 1) == 1) v = -v;
            return $sformatf("%0d", v);
         end
         4, 5: begin
            v = $urandom();
            return $sformatf("%0d", v);
         end
         6: return "2147483647";
         7: return "-2147483648";
         8: return "-0";
         9: return $sformatf("00%0d", $urandom_range(0, 99));
         10: return "2147483648";
         11: return "-2147483649";
         12: return "-";
         13: return "";
         14: return $sformatf("%0dz", $urandom_range(0, 9));
         default: return "99999999999";
      endcase
   endfunction

   function automatic string ms_text(input bit clean);
      int unsigned pick;
      logic [63:0] u;
      pick = clean ? $urandom_range(0, 6) : $urandom_range(0, 11);
      case (pick)
         0, 1, 2: return $sformatf("%0d", $urandom_range(0, 99999));
         3, 4: begin
            u = {$urandom(), $urandom()};
            return $sformatf("%0d", u);
         end
         5: return "18446744073709551615";
         6: return $sformatf("000%0d", $urandom_range(0, 999));
         7: return "18446744073709551616";
         8: return "-1";
         9: return "";
         10: return "99999999999999999999";
         default: return "1 2";
      endcase
   endfunction

   function automatic void build_fields(input string head, input int nfields, input int dirty);
      line_bytes.delete();
      append_text(head);
      for (int f = 1; f < nfields; f++) begin
         append_text(",");
         if (f == FIELD_MS) append_text(ms_text(f != dirty));
         else append_text(s32_text(f != dirty));
      end
   endfunction

   function automatic void build_random_line();
      int unsigned kind;
      int          nf;
      int          n;
      string       heads [6];
      heads = '{"OFAD", "OFADCC", "OFADc", "-OFADC", "XFADC", ""};
      kind = $urandom_range(0, 9);
      nf = 9 + $urandom_range(0, 1);
      case (kind)
         6: build_fields("OFADC", $urandom_range(1, 14), -1);
         7: begin
            line_bytes.delete();
            n = $urandom_range(0, 24);
            for (int i = 0; i < n; i++)
               line_bytes.push_back(($urandom_range(0, 4) == 0) ? CHAR_COMMA
                                                                : 8'($urandom_range(0, 255)));
         end
         8: build_fields(heads[$urandom_range(0, 5)], nf, -1);
         9: begin
            build_fields("OFADC", nf, -1);
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
         default: build_fields("OFADC", nf,
                               ($urandom_range(0, 2) == 0) ? $urandom_range(1, nf - 1) : -1);
      endcase
   endfunction

   task automatic test_well_formed();
      send_text("OFADC,1,2,3,4,5,6,7,8", 1'b0);
      send_text({"OFADC,-2147483648,18446744073709551615,2147483647,-2147483648,",
                 "2147483647,0,-0,00012,-7"}, 1'b1);
      send_text("OFADC,0,0,-1,1,1,1,1,1,0", 1'b0);
      send_text("OFADC,0000,0000,0,-0,0,0,0,0,-2147483648", 1'b0);
   endtask

   task automatic test_field_count();
      send_text("", 1'b1);
      send_text("OFADC,1,2,3,4,5,6,7", 1'b0);
      send_text("OFADC,1,2,3,4,5,6,7,8,9,10", 1'b0);
      send_text("OFADC,1,2,3,4,5,6,7,8,9,10,junk,,,,-x", 1'b1);
      send_text(",,,,,,,,", 1'b0);
   endtask

   task automatic test_prefix();
      send_text("OFAD,1,2,3,4,5,6,7,8", 1'b0);
      send_text("OFADCC,1,2,3,4,5,6,7,8", 1'b0);
      send_text("ofadc,1,2,3,4,5,6,7,8", 1'b1);
      send_text("XOFADC,1,2,3,4,5,6,7,8,9", 1'b0);
   endtask

   task automatic test_number_fields();
      send_text("OFADC,2147483648,2,3,4,5,6,7,8", 1'b0);
      send_text("OFADC,-2147483649,2,3,4,5,6,7,8", 1'b0);
      send_text("OFADC,-,2,3,4,5,6,7,8", 1'b0);
      send_text("OFADC,1,-1,3,4,5,6,7,8", 1'b0);
      send_text("OFADC,1,18446744073709551616,3,4,5,6,7,8", 1'b1);
      send_text("OFADC,1,2,1-2,4,5,6,7,8", 1'b0);
      send_text("OFADC,1,2,3,4,5,6,7,8x", 1'b0);
      send_text("OFADC,1,2,3, 4,5,6,7,8", 1'b0);
      send_text("OFADC,1,2,3,4,5,6,7,8,2147483648", 1'b0);
   endtask

   task automatic test_error_priority();
      send_text("OFADC,x,2,y,4,5,6,7,8", 1'b0);
      send_text("XX,x,2,3", 1'b0);
      send_text("OFADC,1,2,3,4,5,q,r,8,9", 1'b0);
   endtask

   task automatic test_end_markers();
      repeat (4) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_text("OFADC,5,6,7,8,9,10,11,12", 1'b1);
      send_text(",", 1'b1);
   endtask

   task automatic test_random_traffic();
      int lines_start;
      int bytes_start;
      lines_start = lines_sent;
      bytes_start = bytes_sent;
      while (bytes_sent - bytes_start < 750 || lines_sent - lines_start < 30) begin
         build_random_line();
         send_line(line_bytes.size() == 0 || $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      line_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_well_formed();
      test_field_count();
      test_prefix();
      test_number_fields();
      test_error_priority();
      test_end_markers();
      test_random_traffic();
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d lines (%0d bytes) with random gaps and stalls.", lines_sent, bytes_sent);
      $display("Checked %0d reports, %0d mismatches.", reports_checked, error_count);
      if (error_count == 0) begin
         $display("adc_csv_packet_parser regression: pass");
      end else begin
         $display("adc_csv_packet_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d reports outstanding.", pending_reports.size());
      $display("adc_csv_packet_parser regression: fail");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/acp_pkg.sv
hw/rtl/acp_stream_if.sv
hw/rtl/acp_token_step.sv
hw/rtl/acp_line_ctrl.sv
hw/rtl/adc_csv_packet_parser.sv
sim/adc_csv_packet_parser_test.sv
